// ===== rtl/core/eafp_pkg.sv =====
package eafp_pkg;

    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int CIDX_W  = 9;     // cell index on the command bus, up to 512 cells

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_start;
        logic [10:0] units_done;
        logic [4:0]  blocks_freed;
    } out_item_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } extent_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CIDX_W-1:0] idx;
        extent_t           data;
    } cell_cmd_t;

endpackage

// ===== rtl/core/eafp_cell.sv =====
module eafp_cell #(
    parameter int               IDX     = 0,
    parameter logic [10:0]      RST_LEN = 11'd0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  eafp_pkg::cell_cmd_t cmd,
    input  eafp_pkg::extent_t   right,
    output eafp_pkg::extent_t   q
);
    import eafp_pkg::*;

    localparam logic [CIDX_W-1:0] MY_IDX = CIDX_W'(IDX);

    extent_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.start  <= '0;
            q_reg.length <= RST_LEN;
        end
        else
        begin
            case (cmd.op)
                CELL_WRITE:
                begin
                    if (cmd.idx == MY_IDX)
                        q_reg <= cmd.data;
                end
                CELL_REMOVE:
                begin
                    // compaction: everything at or above the hole moves down one
                    if (MY_IDX >= cmd.idx)
                        q_reg <= right;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/extent_allocator_fit_policies.sv =====
// Allocation: after accept, the scan reads the free extents in order until an early
// pick or the end of the table, then the commit and the result follow.
// Free mode: per released block, a pop step plus a right and a left scan of the
// extent chain; one item in flight at a time.
// The extent chain is read one cell per cycle, so the scans set the rate.
// Reset (rst_n, async low): pool = POOL_UNITS (max 1024), one free extent, FIFO empty.
// Writing pool_size re-initialises the tables in the same way.
module extent_allocator_fit_policies #(
    parameter int POOL_UNITS  = 1024,
    parameter int ALLOC_SLOTS = 16,
    parameter int FREE_SLOTS  = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  eafp_pkg::in_item_t   in_item,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output eafp_pkg::out_item_t  out_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import eafp_pkg::*;

    localparam int POOL_MAX = (POOL_UNITS > 1024) ? 1024 : POOL_UNITS;
    localparam logic [LEN_W-1:0] POOL_RST = LEN_W'(POOL_MAX);
    localparam int FI_W = $clog2(FREE_SLOTS);
    localparam int FC_W = $clog2(FREE_SLOTS + 1);
    localparam int AH_W = $clog2(ALLOC_SLOTS);
    localparam int AC_W = $clog2(ALLOC_SLOTS + 1);
    localparam logic [FC_W-1:0] FREE_FULL  = FC_W'(FREE_SLOTS);
    localparam logic [AC_W-1:0] ALLOC_FULL = AC_W'(ALLOC_SLOTS);
    localparam logic [AH_W-1:0] ALLOC_LAST = AH_W'(ALLOC_SLOTS - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ASCAN  = 7'b0000010,
        S_ACOMMIT= 7'b0000100,
        S_FPOP   = 7'b0001000,
        S_FRSCAN = 7'b0010000,
        S_FLSCAN = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // ---------------------------------------------------------------
    // Extent chain: cell g holds extent g of the free table
    // ---------------------------------------------------------------
    cell_cmd_t cmd;
    extent_t   cell_q [FREE_SLOTS];

    for (genvar g = 0; g < FREE_SLOTS; g++)
    begin : g_cell
        extent_t right;
        if (g == FREE_SLOTS - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_q[g + 1];
        end
        eafp_cell #(
            .IDX     (g),
            .RST_LEN ((g == 0) ? POOL_RST : LEN_W'(0))
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .right (right),
            .q     (cell_q[g])
        );
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t            state_reg,   state_next;
    logic [1:0]        mode_reg,    mode_next;
    logic [LEN_W-1:0]  req_reg,     req_next;
    logic [FC_W-1:0]   idx_reg,     idx_next;
    logic [FC_W-1:0]   fcount_reg,  fcount_next;
    logic              found_reg,   found_next;
    logic [FC_W-1:0]   pick_reg,    pick_next;
    logic [START_W-1:0] pstart_reg, pstart_next;
    logic [LEN_W-1:0]  plen_reg,    plen_next;
    logic [AH_W-1:0]   ahead_reg,   ahead_next;
    logic [AH_W-1:0]   atail_reg,   atail_next;
    logic [AC_W-1:0]   acount_reg,  acount_next;
    logic [1:0]        status_reg,  status_next;
    logic [START_W-1:0] bstart_reg, bstart_next;
    logic [LEN_W:0]    done_reg,    done_next;
    logic [AC_W-1:0]   freed_reg,   freed_next;
    logic [START_W-1:0] rs_reg,     rs_next;
    logic [LEN_W-1:0]  rl_reg,      rl_next;
    logic [LEN_W-1:0]  pool_reg,    pool_next;
    out_item_t         out_reg,     out_next;
    logic              ovalid_reg,  ovalid_next;

    // allocation FIFO, written at the tail, read at the head
    logic [START_W-1:0] astart_mem [ALLOC_SLOTS];
    logic [LEN_W-1:0]   alen_mem   [ALLOC_SLOTS];
    logic               fifo_we;

    // ---------------------------------------------------------------
    // Handshakes and configuration
    // ---------------------------------------------------------------
    logic       in_acc;
    logic       cfg_wr;
    logic [LEN_W-1:0] cfg_val;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && !paddr[2];
    assign prdata    = 32'(pool_reg);
    assign out_valid = ovalid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        cfg_val = pwdata[LEN_W-1:0];
        if (cfg_val == '0)
            cfg_val = LEN_W'(1);
        else if (cfg_val > POOL_RST)
            cfg_val = POOL_RST;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    extent_t           cur;
    logic              fits;
    logic [LEN_W:0]    rend;
    logic [LEN_W:0]    cend;

    assign cur  = cell_q[idx_reg[FI_W-1:0]];
    assign fits = (cur.length >= req_reg);
    assign rend = {1'b0, LEN_W'(rs_reg)} + {1'b0, rl_reg};
    assign cend = {1'b0, LEN_W'(cur.start)} + {1'b0, cur.length};

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        fcount_next = fcount_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        ahead_next  = ahead_reg;
        atail_next  = atail_reg;
        acount_next = acount_reg;
        status_next = status_reg;
        bstart_next = bstart_reg;
        done_next   = done_reg;
        freed_next  = freed_reg;
        rs_next     = rs_reg;
        rl_next     = rl_reg;
        pool_next   = pool_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        fifo_we     = 1'b0;
        cmd.op      = CELL_HOLD;
        cmd.idx     = '0;
        cmd.data    = '0;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next   = in_item.mode;
                    req_next    = in_item.request_size;
                    status_next = ST_OK;
                    bstart_next = '0;
                    done_next   = '0;
                    freed_next  = '0;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    if (in_item.mode == MODE_FREE)
                        state_next = S_FPOP;
                    else if (acount_reg >= ALLOC_FULL)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (in_item.request_size == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_ASCAN;
                end
            end

            S_ASCAN:
            begin
                if (idx_reg == fcount_reg)
                    state_next = S_ACOMMIT;
                else
                begin
                    idx_next = idx_reg + FC_W'(1);
                    if (fits)
                    begin
                        if (mode_reg == MODE_FIRST
                            || (mode_reg == MODE_BEST && cur.length == req_reg))
                        begin
                            // taken at once
                            pick_next   = idx_reg;
                            pstart_next = cur.start;
                            plen_next   = cur.length;
                            found_next  = 1'b1;
                            state_next  = S_ACOMMIT;
                        end
                        else if (!found_reg
                                 || (mode_reg == MODE_BEST && cur.length < plen_reg)
                                 || (mode_reg == MODE_WORST && cur.length > plen_reg))
                        begin
                            pick_next   = idx_reg;
                            pstart_next = cur.start;
                            plen_next   = cur.length;
                            found_next  = 1'b1;
                        end
                    end
                end
            end

            S_ACOMMIT:
            begin
                state_next = S_DONE;
                if (!found_reg)
                    status_next = ST_NOMEM;
                else
                begin
                    fifo_we     = 1'b1;
                    atail_next  = (atail_reg == ALLOC_LAST) ? '0 : atail_reg + AH_W'(1);
                    acount_next = acount_reg + AC_W'(1);
                    bstart_next = pstart_reg;
                    done_next   = {1'b0, req_reg};
                    cmd.idx     = CIDX_W'(pick_reg);
                    if (plen_reg == req_reg)
                    begin
                        cmd.op      = CELL_REMOVE;
                        fcount_next = fcount_reg - FC_W'(1);
                    end
                    else
                    begin
                        cmd.op          = CELL_WRITE;
                        cmd.data.start  = pstart_reg + START_W'(req_reg);
                        cmd.data.length = plen_reg - req_reg;
                    end
                end
            end

            S_FPOP:
            begin
                if (done_reg < {1'b0, req_reg} && acount_reg != '0)
                begin
                    rs_next     = astart_mem[ahead_reg];
                    rl_next     = alen_mem[ahead_reg];
                    done_next   = done_reg + {1'b0, alen_mem[ahead_reg]};
                    freed_next  = freed_reg + AC_W'(1);
                    ahead_next  = (ahead_reg == ALLOC_LAST) ? '0 : ahead_reg + AH_W'(1);
                    acount_next = acount_reg - AC_W'(1);
                    idx_next    = '0;
                    state_next  = S_FRSCAN;
                end
                else
                begin
                    if (done_reg < {1'b0, req_reg})
                        status_next = ST_SHORT;
                    state_next = S_DONE;
                end
            end

            S_FRSCAN:
            begin
                // right neighbour: an extent starting where the block ends
                if (idx_reg == fcount_reg)
                begin
                    idx_next   = '0;
                    state_next = S_FLSCAN;
                end
                else if ({1'b0, LEN_W'(cur.start)} == rend)
                begin
                    rl_next     = rl_reg + cur.length;
                    cmd.op      = CELL_REMOVE;
                    cmd.idx     = CIDX_W'(idx_reg);
                    fcount_next = fcount_reg - FC_W'(1);
                    idx_next    = '0;
                    state_next  = S_FLSCAN;
                end
                else
                    idx_next = idx_reg + FC_W'(1);
            end

            S_FLSCAN:
            begin
                // left neighbour: an extent ending where the block starts
                if (idx_reg == fcount_reg)
                begin
                    if (fcount_reg < FREE_FULL)
                    begin
                        cmd.op          = CELL_WRITE;
                        cmd.idx         = CIDX_W'(fcount_reg);
                        cmd.data.start  = rs_reg;
                        cmd.data.length = rl_reg;
                        fcount_next     = fcount_reg + FC_W'(1);
                    end
                    state_next = S_FPOP;
                end
                else if (cend == {1'b0, LEN_W'(rs_reg)})
                begin
                    cmd.op          = CELL_WRITE;
                    cmd.idx         = CIDX_W'(idx_reg);
                    cmd.data.start  = cur.start;
                    cmd.data.length = cur.length + rl_reg;
                    state_next      = S_FPOP;
                end
                else
                    idx_next = idx_reg + FC_W'(1);
            end

            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    out_next.status       = status_reg;
                    out_next.block_start  = bstart_reg;
                    out_next.units_done   = done_reg[LEN_W-1:0];
                    out_next.blocks_freed = 5'(freed_reg);
                    ovalid_next           = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // pool_size write: the user must write only while idle; the block does not enforce it
        if (cfg_wr)
        begin
            pool_next       = cfg_val;
            cmd.op          = CELL_WRITE;
            cmd.idx         = '0;
            cmd.data.start  = '0;
            cmd.data.length = cfg_val;
            fcount_next     = FC_W'(1);
            ahead_next      = '0;
            atail_next      = '0;
            acount_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fcount_reg <= FC_W'(1);
            ahead_reg  <= '0;
            atail_reg  <= '0;
            acount_reg <= '0;
            pool_reg   <= POOL_RST;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fcount_reg <= fcount_next;
            ahead_reg  <= ahead_next;
            atail_reg  <= atail_next;
            acount_reg <= acount_next;
            pool_reg   <= pool_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        pick_reg   <= pick_next;
        pstart_reg <= pstart_next;
        plen_reg   <= plen_next;
        status_reg <= status_next;
        bstart_reg <= bstart_next;
        done_reg   <= done_next;
        freed_reg  <= freed_next;
        rs_reg     <= rs_next;
        rl_reg     <= rl_next;
        out_reg    <= out_next;
        if (fifo_we)
        begin
            astart_mem[atail_reg] <= pstart_reg;
            alen_mem[atail_reg]   <= req_reg;
        end
    end

endmodule
